// ===== hdl/srne_pkg.sv =====
package srne_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // one tracker event
  typedef struct packed {
    logic        is_track;
    logic [1:0]  track;
    logic [3:0]  param;
    logic [11:0] value;
  } event_t;

  // per-voice parameter codes
  localparam logic [3:0] P_NOTE    = 4'd0;
  localparam logic [3:0] P_WAVE0   = 4'd1;
  localparam logic [3:0] P_PULSE   = 4'd9;
  localparam logic [3:0] P_FILT_EN = 4'd10;
  localparam logic [3:0] P_ATTACK  = 4'd11;
  // global parameter codes
  localparam logic [3:0] G_CUTOFF  = 4'd0;
  localparam logic [3:0] G_RES     = 4'd1;
  localparam logic [3:0] G_FTYPE   = 4'd2;
  localparam logic [3:0] G_VOLUME  = 4'd3;

  localparam logic [7:0] WAVE_MIN  = 8'h10;

  function automatic logic [15:0] tuning(input logic [6:0] idx);
    logic [15:0] r;
    case (idx)
      7'd0:  r = 16'h0117; 7'd1:  r = 16'h0127; 7'd2:  r = 16'h0139; 7'd3:  r = 16'h014b;
      7'd4:  r = 16'h015f; 7'd5:  r = 16'h0174; 7'd6:  r = 16'h018a; 7'd7:  r = 16'h01a1;
      7'd8:  r = 16'h01ba; 7'd9:  r = 16'h01d4; 7'd10: r = 16'h01f0; 7'd11: r = 16'h020e;
      7'd12: r = 16'h022d; 7'd13: r = 16'h024e; 7'd14: r = 16'h0271; 7'd15: r = 16'h0296;
      7'd16: r = 16'h02be; 7'd17: r = 16'h02e8; 7'd18: r = 16'h0314; 7'd19: r = 16'h0343;
      7'd20: r = 16'h0374; 7'd21: r = 16'h03a9; 7'd22: r = 16'h03e1; 7'd23: r = 16'h041c;
      7'd24: r = 16'h045a; 7'd25: r = 16'h049c; 7'd26: r = 16'h04e2; 7'd27: r = 16'h052d;
      7'd28: r = 16'h057c; 7'd29: r = 16'h05cf; 7'd30: r = 16'h0628; 7'd31: r = 16'h0685;
      7'd32: r = 16'h06e8; 7'd33: r = 16'h0752; 7'd34: r = 16'h07c1; 7'd35: r = 16'h0837;
      7'd36: r = 16'h08b4; 7'd37: r = 16'h0939; 7'd38: r = 16'h09c5; 7'd39: r = 16'h0a5a;
      7'd40: r = 16'h0af7; 7'd41: r = 16'h0b9e; 7'd42: r = 16'h0c4f; 7'd43: r = 16'h0d0a;
      7'd44: r = 16'h0dd1; 7'd45: r = 16'h0ea3; 7'd46: r = 16'h0f82; 7'd47: r = 16'h106e;
      7'd48: r = 16'h1168; 7'd49: r = 16'h1271; 7'd50: r = 16'h138a; 7'd51: r = 16'h14b3;
      7'd52: r = 16'h15ee; 7'd53: r = 16'h173c; 7'd54: r = 16'h189e; 7'd55: r = 16'h1a15;
      7'd56: r = 16'h1ba2; 7'd57: r = 16'h1d46; 7'd58: r = 16'h1f04; 7'd59: r = 16'h20dc;
      7'd60: r = 16'h22d0; 7'd61: r = 16'h24e2; 7'd62: r = 16'h2714; 7'd63: r = 16'h2967;
      7'd64: r = 16'h2bdd; 7'd65: r = 16'h2e79; 7'd66: r = 16'h313c; 7'd67: r = 16'h3429;
      7'd68: r = 16'h3744; 7'd69: r = 16'h3a8d; 7'd70: r = 16'h3e08; 7'd71: r = 16'h41b8;
      7'd72: r = 16'h45a1; 7'd73: r = 16'h49c5; 7'd74: r = 16'h4e28; 7'd75: r = 16'h52cd;
      7'd76: r = 16'h57ba; 7'd77: r = 16'h5cf1; 7'd78: r = 16'h6278; 7'd79: r = 16'h6853;
      7'd80: r = 16'h6e87; 7'd81: r = 16'h751a; 7'd82: r = 16'h7c10; 7'd83: r = 16'h8371;
      7'd84: r = 16'h8b42; 7'd85: r = 16'h9389; 7'd86: r = 16'h9c4f; 7'd87: r = 16'ha59b;
      7'd88: r = 16'haf74; 7'd89: r = 16'hb9e2; 7'd90: r = 16'hc4f0; 7'd91: r = 16'hd0a6;
      7'd92: r = 16'hdd0e; 7'd93: r = 16'hea33; 7'd94: r = 16'hf820;
      default: r = 16'hffff;
    endcase
    return r;
  endfunction

  // note index to octave*16 + semitone + 1
  // n*43/512 is exact floor(n/12) for every 7-bit index
  function automatic logic [11:0] note_code(input logic [6:0] n);
    logic [3:0]  oct;
    logic [6:0]  rem;
    logic [12:0] prod;
    prod = 13'(n) * 13'd43;
    oct  = prod[12:9];
    rem  = n - 7'(oct) * 7'd12;
    if (rem >= 7'd12) begin
      oct = oct + 4'd1;
      rem = rem - 7'd12;
    end
    return {4'd0, oct, 4'd0} + {5'd0, rem} + 12'd1;
  endfunction

endpackage

// ===== hdl/sid_register_to_note_events_core.sv =====
// Channel | dir | fields
// in_     | in  | tdata: cmd, voice, freq, pulse, wave, adsr, cutoff, res_route,
//         |     |        mode_vol, frame_time
// out_    | out | tdata: is_track, track, param, value, event_time; tlast: last
//
// A filter snapshot is decoded when it is accepted, then makes up to 7 transfers out.
// A voice snapshot that needs a note search runs the frequency down a chain
// of NOTE_COUNT cells in the search state, loads the note in the drain state,
// then makes up to 14 transfers out.
// Events are held in a small list and sent one per cycle while out_tready is
// high; a stall just holds the current event. in_tready is high only in idle.
// Reset (rst_n low, synchronous) clears all previous-snapshot state.
module sid_register_to_note_events_core #(
  parameter int NOTE_COUNT = 96,
  parameter int VOICES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // lsb up: cmd[0] voice[2:1] freq[18:3] pulse[30:19] wave[38:31] adsr[54:39]
  // cutoff[65:55] res_route[73:66] mode_vol[81:74] frame_time[97:82] pad
  input  logic [103:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lsb up: is_track[0] track[2:1] param[6:3] value[18:7] event_time[34:19] pad
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  localparam int IDX_W = $clog2(NOTE_COUNT);
  localparam int CNT_W = $clog2(NOTE_COUNT + 2);
  localparam int MAXEV = 14;

  // input fields
  logic        cmd;
  logic [1:0]  voice;
  logic [15:0] freq, adsr, frame_time;
  logic [11:0] pulse;
  logic [7:0]  wave, res_route, mode_vol;
  logic [10:0] cutoff;
  assign cmd        = in_tdata[0];
  assign voice      = in_tdata[2:1];
  assign freq       = in_tdata[18:3];
  assign pulse      = in_tdata[30:19];
  assign wave       = in_tdata[38:31];
  assign adsr       = in_tdata[54:39];
  assign cutoff     = in_tdata[65:55];
  assign res_route  = in_tdata[73:66];
  assign mode_vol   = in_tdata[81:74];
  assign frame_time = in_tdata[97:82];

  // state
  logic [15:0]      prev_freq_r  [VOICES];
  logic [7:0]       prev_wave_r  [VOICES];
  logic [15:0]      prev_adsr_r  [VOICES];
  logic [11:0]      prev_pulse_r [VOICES];
  logic [IDX_W-1:0] cur_note_r   [VOICES];
  logic [10:0] prev_cutoff_r;
  logic [7:0]  prev_rr_r, prev_mv_r;

  srne_pkg::state_t state_r, state_nxt;
  srne_pkg::event_t ev_r [MAXEV];
  logic [MAXEV-1:0] evv_r;       // valid mask of queued events
  logic [3:0]  rd_r;             // next event to send
  logic [15:0] time_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]  v_r;
  logic        retrig_r;
  logic        search_en;
  logic [IDX_W-1:0] found;
  logic [15:0] freq_hold_r;

  srne_chain #(.NOTE_COUNT(NOTE_COUNT), .IDX_W(IDX_W)) u_chain (
    .clk  (clk),
    .en   (search_en),
    .freq (freq_hold_r),
    .note (found)
  );

  // frequency held steady at the chain head while the search runs
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) freq_hold_r <= freq;
  end
  assign search_en = (state_r == srne_pkg::ST_SEARCH);

  logic in_xfer, all, retrig, do_search, v_ok;
  logic [7:0] pw;
  logic [15:0] pa;
  assign in_xfer = in_tvalid && in_tready;
  assign all     = (frame_time == 16'd0);
  assign v_ok    = (32'(voice) < VOICES);
  assign pw      = v_ok ? prev_wave_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]] : 8'd0;
  assign pa      = v_ok ? prev_adsr_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]] : 16'd0;
  assign retrig  = (wave >= srne_pkg::WAVE_MIN) && wave[0] &&
                   (!pw[0] || pw < srne_pkg::WAVE_MIN);
  assign do_search = !cmd && v_ok && (wave >= srne_pkg::WAVE_MIN) &&
      (all || retrig ||
       freq != prev_freq_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]);

  // build the event list for a snapshot (note slot 0 filled after search)
  srne_pkg::event_t ev_nxt [MAXEV];
  logic [MAXEV-1:0] evv_nxt;
  always_comb begin
    for (int i = 0; i < MAXEV; i++) ev_nxt[i] = '0;
    evv_nxt = '0;
    if (!cmd) begin
      for (int b = 0; b < 8; b++) begin
        ev_nxt[1+b] = '{1'b1, voice, 4'(srne_pkg::P_WAVE0 + 4'(b)), {11'd0, wave[b]}};
        evv_nxt[1+b] = all || (wave[b] != pw[b]);
      end
      for (int b = 0; b < 4; b++) begin
        ev_nxt[9+b] = '{1'b1, voice, 4'(srne_pkg::P_ATTACK + 4'(b)),
                        {8'd0, adsr[12-4*b +: 4]}};
        evv_nxt[9+b] = all || (adsr[12-4*b +: 4] != pa[12-4*b +: 4]);
      end
      ev_nxt[13] = '{1'b1, voice, srne_pkg::P_PULSE, pulse};
      evv_nxt[13] = all ||
          (pulse != prev_pulse_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]);
      if (!v_ok) evv_nxt = '0;
    end else begin
      ev_nxt[0] = '{1'b0, 2'd0, srne_pkg::G_CUTOFF, {1'b0, cutoff}};
      evv_nxt[0] = all || (cutoff != prev_cutoff_r);
      ev_nxt[1] = '{1'b0, 2'd0, srne_pkg::G_RES, {8'd0, res_route[7:4]}};
      evv_nxt[1] = all || (res_route != prev_rr_r);
      for (int b = 0; b < 3; b++) begin
        ev_nxt[2+b] = '{1'b1, 2'(b), srne_pkg::P_FILT_EN, {11'd0, res_route[b]}};
        evv_nxt[2+b] = evv_nxt[1];
      end
      ev_nxt[5] = '{1'b0, 2'd0, srne_pkg::G_FTYPE, {10'd0, mode_vol[5:4]}};
      evv_nxt[5] = all || (mode_vol[6:4] != prev_mv_r[6:4]);
      ev_nxt[6] = '{1'b0, 2'd0, srne_pkg::G_VOLUME, {8'd0, mode_vol[3:0]}};
      evv_nxt[6] = all || (mode_vol[3:0] != prev_mv_r[3:0]);
    end
  end

  // next valid entry at or after the read pointer
  logic [MAXEV-1:0] rem_mask;
  logic [3:0] cur_idx;
  logic       any_left, more_after;
  always_comb begin
    cur_idx = '0;
    any_left = 1'b0;
    more_after = 1'b0;
    for (int i = MAXEV - 1; i >= 0; i--) begin
      rem_mask[i] = evv_r[i] && (4'(i) >= rd_r);
      if (rem_mask[i]) begin
        cur_idx = 4'(i);
        more_after = any_left;
        any_left = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srne_pkg::ST_IDLE:   if (in_xfer) state_nxt = do_search ? srne_pkg::ST_SEARCH
                                                              : srne_pkg::ST_EMIT;
      srne_pkg::ST_SEARCH: if (32'(cnt_r) == NOTE_COUNT) state_nxt = srne_pkg::ST_DRAIN;
      srne_pkg::ST_DRAIN:  state_nxt = srne_pkg::ST_EMIT;
      srne_pkg::ST_EMIT:   if (!any_left || (out_tready && !more_after))
                             state_nxt = srne_pkg::ST_IDLE;
      default:             state_nxt = srne_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= srne_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        prev_freq_r[i] <= '0; prev_wave_r[i] <= '0; prev_adsr_r[i] <= '0;
        prev_pulse_r[i] <= '0; cur_note_r[i] <= '0;
      end
      prev_cutoff_r <= '0; prev_rr_r <= '0; prev_mv_r <= '0;
      evv_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      case (state_r)
        srne_pkg::ST_IDLE: if (in_xfer) begin
          ev_r     <= ev_nxt;
          evv_r    <= evv_nxt;
          rd_r     <= '0;
          cnt_r    <= '0;
          time_r   <= frame_time;
          v_r      <= voice;
          retrig_r <= retrig;
          if (!cmd && v_ok) begin
            prev_freq_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]  <= freq;
            prev_wave_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]  <= wave;
            prev_adsr_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]  <= adsr;
            prev_pulse_r[voice[$clog2(VOICES > 1 ? VOICES : 2)-1:0]] <= pulse;
          end
          if (cmd) begin
            prev_cutoff_r <= cutoff; prev_rr_r <= res_route; prev_mv_r <= mode_vol;
          end
        end
        srne_pkg::ST_SEARCH: cnt_r <= cnt_r + CNT_W'(1);
        srne_pkg::ST_DRAIN: begin
          ev_r[0]  <= '{1'b1, v_r, srne_pkg::P_NOTE, srne_pkg::note_code(7'(found))};
          evv_r[0] <= retrig_r ||
                      (found != cur_note_r[v_r[$clog2(VOICES > 1 ? VOICES : 2)-1:0]]);
          cur_note_r[v_r[$clog2(VOICES > 1 ? VOICES : 2)-1:0]] <= found;
        end
        srne_pkg::ST_EMIT: if (out_tready && any_left) rd_r <= cur_idx + 4'd1;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == srne_pkg::ST_IDLE);
  assign out_tvalid = (state_r == srne_pkg::ST_EMIT) && any_left;
  assign out_tlast  = !more_after;
  assign out_tdata  = {5'd0, time_r, ev_r[cur_idx].value, ev_r[cur_idx].param,
                       ev_r[cur_idx].track, ev_r[cur_idx].is_track};

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != srne_pkg::ST_IDLE) |-> !in_tready) else $error("in_tready while busy");
  a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srne_pkg::ST_DRAIN) |-> $past(state_r == srne_pkg::ST_SEARCH))
    else $error("drain without search");
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == srne_pkg::ST_EMIT)) else $error("output outside emit");
`endif
endmodule

// ===== hdl/srne_cell.sv =====
// One search cell: compares the passing frequency with its own tuning entry
// and hands the running best (distance, index) to its neighbor.
module srne_cell #(
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  logic             en,
  input  logic [15:0]      entry,
  input  logic [IDX_W-1:0] my_idx,
  input  logic [15:0]      f_in,
  input  logic [16:0]      best_in,
  input  logic [IDX_W-1:0] idx_in,
  output logic [15:0]      f_out,
  output logic [16:0]      best_out,
  output logic [IDX_W-1:0] idx_out
);
  logic [16:0] gap;
  logic [15:0]      f_r;
  logic [16:0]      best_r;
  logic [IDX_W-1:0] idx_r;

  assign gap = (f_in > entry) ? {1'b0, f_in - entry} : {1'b0, entry - f_in};

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_in;
      if (gap < best_in) begin
        best_r <= gap;
        idx_r  <= my_idx;
      end else begin
        best_r <= best_in;
        idx_r  <= idx_in;
      end
    end
  end

  assign f_out    = f_r;
  assign best_out = best_r;
  assign idx_out  = idx_r;
endmodule

// ===== hdl/srne_chain.sv =====
// Row of search cells; the frequency enters at cell 0 and the winner leaves
// the last cell after passing through the registers of every cell.
module srne_chain #(
  parameter int NOTE_COUNT = 96,
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  logic             en,
  input  logic [15:0]      freq,
  output logic [IDX_W-1:0] note
);
  logic [15:0]      f_w    [NOTE_COUNT+1];
  logic [16:0]      best_w [NOTE_COUNT+1];
  logic [IDX_W-1:0] idx_w  [NOTE_COUNT+1];

  assign f_w[0]    = freq;
  assign best_w[0] = 17'h1ffff;
  assign idx_w[0]  = '0;

  for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_cell
    srne_cell #(.IDX_W(IDX_W)) u_cell (
      .clk      (clk),
      .en       (en),
      .entry    (srne_pkg::tuning(7'(g))),
      .my_idx   (IDX_W'(g)),
      .f_in     (f_w[g]),
      .best_in  (best_w[g]),
      .idx_in   (idx_w[g]),
      .f_out    (f_w[g+1]),
      .best_out (best_w[g+1]),
      .idx_out  (idx_w[g+1])
    );
  end

  assign note = idx_w[NOTE_COUNT];
endmodule

// ===== tb/tb.sv =====
module tb;

  // one expected tracker event
  typedef struct {
    logic        is_track;
    logic [1:0]  track;
    logic [3:0]  param;
    logic [11:0] value;
    logic [15:0] event_time;
    logic        last;
  } note_event_t;

  // snapshot fields
  typedef struct {
    logic        cmd;
    logic [1:0]  voice;
    logic [15:0] freq;
    logic [11:0] pulse;
    logic [7:0]  wave;
    logic [15:0] adsr;
    logic [10:0] cutoff;
    logic [7:0]  res_route;
    logic [7:0]  mode_vol;
    logic [15:0] frame_time;
  } snapshot_t;

  localparam int NoteCount = 96;
  localparam int Voices = 3;

  // independent tuning table
  localparam logic [15:0] TUNE [0:95] = '{
    16'h0117,16'h0127,16'h0139,16'h014b,16'h015f,16'h0174,16'h018a,16'h01a1,16'h01ba,16'h01d4,
    16'h01f0,16'h020e,16'h022d,16'h024e,16'h0271,16'h0296,16'h02be,16'h02e8,16'h0314,16'h0343,
    16'h0374,16'h03a9,16'h03e1,16'h041c,16'h045a,16'h049c,16'h04e2,16'h052d,16'h057c,16'h05cf,
    16'h0628,16'h0685,16'h06e8,16'h0752,16'h07c1,16'h0837,16'h08b4,16'h0939,16'h09c5,16'h0a5a,
    16'h0af7,16'h0b9e,16'h0c4f,16'h0d0a,16'h0dd1,16'h0ea3,16'h0f82,16'h106e,16'h1168,16'h1271,
    16'h138a,16'h14b3,16'h15ee,16'h173c,16'h189e,16'h1a15,16'h1ba2,16'h1d46,16'h1f04,16'h20dc,
    16'h22d0,16'h24e2,16'h2714,16'h2967,16'h2bdd,16'h2e79,16'h313c,16'h3429,16'h3744,16'h3a8d,
    16'h3e08,16'h41b8,16'h45a1,16'h49c5,16'h4e28,16'h52cd,16'h57ba,16'h5cf1,16'h6278,16'h6853,
    16'h6e87,16'h751a,16'h7c10,16'h8371,16'h8b42,16'h9389,16'h9c4f,16'ha59b,16'haf74,16'hb9e2,
    16'hc4f0,16'hd0a6,16'hdd0e,16'hea33,16'hf820,16'hffff};

  // Tracks previous register snapshots and holds the events still owed by the block.
  class event_scoreboard;
    logic [15:0] last_freq [Voices];
    logic [7:0]  last_wave [Voices];
    logic [15:0] last_adsr [Voices];
    logic [11:0] last_pulse [Voices];
    logic [6:0]  note_now [Voices];
    logic [10:0] last_cutoff;
    logic [7:0]  last_res_route;
    logic [7:0]  last_mode_vol;
    note_event_t pending_events[$];
    int errors;
    int events_seen;
    int voice_items;
    int filter_items;

    function new();
      errors = 0;
      events_seen = 0;
      voice_items = 0;
      filter_items = 0;
      for (int i = 0; i < Voices; i++) begin
        last_freq[i] = '0;
        last_wave[i] = '0;
        last_adsr[i] = '0;
        last_pulse[i] = '0;
        note_now[i] = '0;
      end
      last_cutoff = '0;
      last_res_route = '0;
      last_mode_vol = '0;
    endfunction

    function void push(logic it, logic [1:0] tr, logic [3:0] p, logic [11:0] v,
                       logic [15:0] t);
      note_event_t e;
      e.is_track = it;
      e.track = tr;
      e.param = p;
      e.value = v;
      e.event_time = t;
      e.last = 1'b0;
      pending_events.push_back(e);
    endfunction

    function logic [6:0] closest_note(logic [15:0] f);
      int best;
      int gap;
      logic [6:0] idx;
      best = 32'h7fffffff;
      idx = '0;
      for (int d = 0; d < NoteCount; d++) begin
        gap = (f > TUNE[d]) ? int'(f) - int'(TUNE[d]) : int'(TUNE[d]) - int'(f);
        if (gap < best) begin
          best = gap;
          idx = 7'(d);
        end
      end
      return idx;
    endfunction

    // work out the events of one accepted snapshot
    function void note_snapshot(snapshot_t s);
      int start_cnt;
      logic all;
      logic retrig;
      logic [7:0] pw;
      logic [15:0] pa;
      logic [6:0] nt;
      logic [3:0] nn;
      int v;
      start_cnt = pending_events.size();
      all = (s.frame_time == 16'd0);
      v = s.voice;
      if (!s.cmd) begin
        if (v < Voices) begin
          voice_items++;
          pw = last_wave[v];
          pa = last_adsr[v];
          retrig = (s.wave >= srne_pkg::WAVE_MIN) && s.wave[0] &&
                   (!pw[0] || pw < srne_pkg::WAVE_MIN);
          if ((all || retrig || s.freq != last_freq[v]) && s.wave >= srne_pkg::WAVE_MIN) begin
            nt = closest_note(s.freq);
            if (retrig || nt != note_now[v])
              push(1'b1, s.voice, srne_pkg::P_NOTE,
                   12'(((int'(nt) / 12) << 4) + (int'(nt) % 12) + 1), s.frame_time);
            note_now[v] = nt;
          end
          for (int b = 0; b < 8; b++)
            if (all || s.wave[b] != pw[b])
              push(1'b1, s.voice, srne_pkg::P_WAVE0 + 4'(b), 12'(s.wave[b]), s.frame_time);
          for (int b = 0; b < 4; b++) begin
            nn = 4'(s.adsr >> (12 - 4 * b));
            if (all || nn != 4'(pa >> (12 - 4 * b)))
              push(1'b1, s.voice, srne_pkg::P_ATTACK + 4'(b), 12'(nn), s.frame_time);
          end
          if (all || s.pulse != last_pulse[v])
            push(1'b1, s.voice, srne_pkg::P_PULSE, s.pulse, s.frame_time);
          last_freq[v] = s.freq;
          last_wave[v] = s.wave;
          last_adsr[v] = s.adsr;
          last_pulse[v] = s.pulse;
        end
      end else begin
        filter_items++;
        if (all || s.cutoff != last_cutoff)
          push(1'b0, 2'd0, srne_pkg::G_CUTOFF, 12'(s.cutoff), s.frame_time);
        if (all || s.res_route != last_res_route) begin
          push(1'b0, 2'd0, srne_pkg::G_RES, 12'(s.res_route[7:4]), s.frame_time);
          for (int b = 0; b < 3; b++)
            push(1'b1, 2'(b), srne_pkg::P_FILT_EN, 12'(s.res_route[b]), s.frame_time);
        end
        if (all || s.mode_vol[6:4] != last_mode_vol[6:4])
          push(1'b0, 2'd0, srne_pkg::G_FTYPE, 12'(s.mode_vol[5:4]), s.frame_time);
        if (all || s.mode_vol[3:0] != last_mode_vol[3:0])
          push(1'b0, 2'd0, srne_pkg::G_VOLUME, 12'(s.mode_vol[3:0]), s.frame_time);
        last_cutoff = s.cutoff;
        last_res_route = s.res_route;
        last_mode_vol = s.mode_vol;
      end
      if (pending_events.size() > start_cnt)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(logic [39:0] d, logic l);
      note_event_t e;
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: tdata=%h tlast=%b", d, l);
        errors++;
        return;
      end
      e = pending_events.pop_front();
      if (d[0] !== e.is_track) begin
        $error("is_track: expected %0d, got %0d", e.is_track, d[0]);
        errors++;
      end
      if (d[2:1] !== e.track) begin
        $error("track: expected %0d, got %0d", e.track, d[2:1]);
        errors++;
      end
      if (d[6:3] !== e.param) begin
        $error("param: expected %0d, got %0d", e.param, d[6:3]);
        errors++;
      end
      if (d[18:7] !== e.value) begin
        $error("value: expected %h, got %h", e.value, d[18:7]);
        errors++;
      end
      if (d[34:19] !== e.event_time) begin
        $error("event_time: expected %h, got %h", e.event_time, d[34:19]);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %b, got %b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // cmd, voice, freq, pulse, wave, adsr, cutoff, res_route,
                            // mode_vol, frame_time
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;  // is_track, track, param, value, event_time
  logic         out_tlast;

  event_scoreboard sb;
  bit sender_idles;   // random gaps on the input side
  bit sink_idles;     // random stalls on the output side
  int hold_cycles;    // long output hold-off, counted by the sink process
  bit done;

  sid_register_to_note_events_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [103:0] pack_snapshot(snapshot_t s);
    return {6'd0, s.frame_time, s.mode_vol, s.res_route, s.cutoff, s.adsr, s.wave,
            s.pulse, s.freq, s.voice, s.cmd};
  endfunction

  // offer one snapshot, with an optional random gap first; valid stays up
  // after the transfer until the next gap or the next snapshot
  task automatic send_snapshot(snapshot_t s);
    if (sender_idles) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_snapshot(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_snapshot(s);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic snapshot_t random_snapshot(int voice_bias);
    snapshot_t s;
    s.cmd = ($urandom_range(99) < 25);
    s.voice = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    case ($urandom_range(3))
      0: s.freq = 16'($urandom);
      1: s.freq = TUNE[$urandom_range(95)];
      2: s.freq = TUNE[$urandom_range(95)] + 16'($urandom_range(40)) - 16'd20;
      default: s.freq = 16'($urandom_range(16'h0200));
    endcase
    s.pulse = 12'($urandom);
    // mostly musical waveforms, toggling the gate
    s.wave = ($urandom_range(9) < 8) ? {4'($urandom_range(1, 15)), 3'($urandom), 1'($urandom)}
                                     : 8'($urandom);
    s.adsr = ($urandom_range(1)) ? 16'($urandom) : 16'h09a0;
    s.cutoff = 11'($urandom);
    s.res_route = ($urandom_range(1)) ? 8'($urandom) : 8'h71;
    s.mode_vol = ($urandom_range(1)) ? 8'($urandom) : 8'h1f;
    s.frame_time = ($urandom_range(29) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    if (voice_bias >= 0) begin
      s.cmd = 1'b0;
      s.voice = 2'(voice_bias);
    end
    return s;
  endfunction

  // output side: random stalls, and a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= sink_idles ? ($urandom_range(99) >= 28) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_event(out_tdata, out_tlast);
  end

  initial begin
    snapshot_t s;
    sb = new();
    done = 0;
    hold_cycles = 0;
    sender_idles = 0;
    sink_idles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-fields frames at time zero for voices 0 and 1 and for the filter
    s = '{cmd:0, voice:0, freq:16'h0000, pulse:12'h000, wave:8'h00, adsr:16'h0000,
          cutoff:11'h000, res_route:8'h00, mode_vol:8'h00, frame_time:16'd0};
    send_snapshot(s);
    s.voice = 2'd1; s.freq = 16'hffff; s.pulse = 12'hfff; s.wave = 8'hff; s.adsr = 16'hffff;
    send_snapshot(s);   // key-on at the top of the table
    s.voice = 2'd2; s.freq = 16'h0000; s.wave = 8'h11; s.frame_time = 16'hffff;
    send_snapshot(s);   // key-on at the bottom
    s.freq = 16'h011f;  // exactly between two entries: lower index wins
    s.wave = 8'h21;
    send_snapshot(s);
    s.wave = 8'h0f;     // below waveform threshold: no search
    s.freq = 16'h4000; s.frame_time = 16'd2;
    send_snapshot(s);
    s.wave = 8'h41;     // re-key after low waveform
    send_snapshot(s);
    s.wave = 8'h40;  s.frame_time = 16'd3;
    send_snapshot(s);
    s.wave = 8'h41;     // gate retrigger with same note
    send_snapshot(s);
    s.voice = 2'd3;     // out of range voice
    send_snapshot(s);
    s = '{cmd:1, voice:0, freq:16'h0, pulse:12'h0, wave:8'h0, adsr:16'h0,
          cutoff:11'h7ff, res_route:8'hff, mode_vol:8'hff, frame_time:16'd0};
    send_snapshot(s);
    s.mode_vol = 8'hbf; s.frame_time = 16'd5;  // volume same, high-pass bit only
    send_snapshot(s);
    s.mode_vol = 8'hb0; send_snapshot(s);
    s.res_route = 8'hfe; send_snapshot(s);
    s.cutoff = 11'h000; s.res_route = 8'h00; send_snapshot(s);
    send_snapshot(s);   // nothing changed
    wait_drained();

    // random, first without idling
    for (int i = 0; i < 60; i++) send_snapshot(random_snapshot(-1));
    sender_idles = 1;
    sink_idles = 1;
    for (int i = 0; i < 180; i++) send_snapshot(random_snapshot(-1));

    // sink holds off while snapshots keep coming
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_snapshot(random_snapshot(int'($urandom_range(2))));
    wait_drained();   // sender pauses until all events are out

    for (int i = 0; i < 180; i++) send_snapshot(random_snapshot(-1));
    wait_drained();
    repeat (300) @(posedge clk);
    done = 1;
    $display("Covered %0d voice and %0d filter snapshots, %0d events checked.",
             sb.voice_items, sb.filter_items, sb.events_seen);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    if (!done) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
